// ===== rtl/core/cd_pkg.sv =====
// ----------------------------------------------------------------------------
// cd_pkg: shared types and constants of the circular deque
// sizes of the rotating ring, operation and status codes, pointer helpers
// ----------------------------------------------------------------------------
package cd_pkg;

  localparam int DEPTH  = 1024;
  localparam int DATA_W = 32;
  localparam int OUT_W  = 32;
  localparam int CAP_W  = 11;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(1024);

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_HOLD
  } state_e;

  // write request from the controller into the ring
  typedef struct packed {
    logic  wr_en;
    data_t wr_data;
  } ring_ctl_t;

  // pointer step forward, wraps to 0 at the capacity
  function automatic idx_t ptr_inc(idx_t p, cnt_t cap);
    cnt_t n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  // pointer step back, wraps to capacity-1 from 0 or from the capacity or beyond
  function automatic idx_t ptr_dec(idx_t p, cnt_t cap);
    idx_t r;
    if (p == '0 || CNT_W'(p) >= cap) begin
      r = IDX_W'(cap - CNT_W'(1));
    end else begin
      r = p - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cd_intf.sv =====
// ----------------------------------------------------------------------------
// cd_intf: valid/ready channels of the circular deque
// request words, response words and the capacity write channel
// ----------------------------------------------------------------------------
interface cd_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface cd_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink   (input valid, input status, input popped_value, output ready);
endinterface

interface cd_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cd_cell.sv =====
// ----------------------------------------------------------------------------
// cd_cell: one entry of the rotating ring
// takes its neighbor's entry every cycle, or the write data when selected
// ----------------------------------------------------------------------------
module cd_cell (
  input  logic          clk_i,
  input  cd_pkg::data_t shift_i,
  input  logic          wr_en_i,
  input  cd_pkg::data_t wr_data_i,
  output cd_pkg::data_t data_o
);
  import cd_pkg::*;

  data_t data_q;
  data_t data_d;

  assign data_d = wr_en_i ? wr_data_i : shift_i;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/cd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cd_ctrl: deque sequencer
// head, tail, count and capacity; waits for the entry at the ring port
// ----------------------------------------------------------------------------
module cd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  cd_cfg_if.sink            cfg,
  cd_req_if.sink            req,
  cd_rsp_if.source          rsp,
  input  cd_pkg::data_t     port_data_i,
  output cd_pkg::ring_ctl_t ring_o
);
  import cd_pkg::*;

  state_e st_q, st_d;
  idx_t   head_q, head_d;
  idx_t   tail_q, tail_d;
  cnt_t   count_q, count_d;
  idx_t   rot_q, rot_d;
  idx_t   target_q, target_d;
  logic   is_wr_q, is_wr_d;
  data_t  wdata_q, wdata_d;
  logic [CAP_W-1:0] cap_q;

  logic              res_load;
  logic [1:0]        res_status_q, res_status_d;
  logic [OUT_W-1:0]  res_val_q, res_val_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [1:0]        out_status_q, out_status_d;
  logic [OUT_W-1:0]  out_val_q, out_val_d;

  logic              out_free;
  logic [CMP_W-1:0]  cap_wide;
  cnt_t              cap_eff;
  idx_t              dec_head;
  idx_t              dec_tail;
  logic [1:0]        fin_status;
  logic [OUT_W-1:0]  fin_val;

  // capacity zero acts as one, above the ring size saturates
  always_comb begin
    cap_wide = CMP_W'(cap_q);
    if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_wide);
    end
  end

  assign dec_head  = ptr_dec(head_q, cap_eff);
  assign dec_tail  = ptr_dec(tail_q, cap_eff);
  assign out_free  = !out_valid_q || rsp.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    st_d         = st_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    target_d     = target_q;
    is_wr_d      = is_wr_q;
    wdata_d      = wdata_q;
    rot_d        = (rot_q == IDX_W'(DEPTH - 1)) ? '0 : rot_q + IDX_W'(1);
    req.ready    = 1'b0;
    ring_o       = '{wr_en: 1'b0, wr_data: wdata_q};
    fin_status   = ST_OK;
    fin_val      = '0;
    out_load     = 1'b0;
    res_load     = 1'b0;

    case (st_q)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          wdata_d = DATA_W'(req.value);
          is_wr_d = (req.op == OP_PUSH_FRONT) || (req.op == OP_PUSH_BACK);
          if (is_wr_d && count_q >= cap_eff) begin
            fin_status = ST_FULL;
          end else if (!is_wr_d && count_q == '0) begin
            fin_status = ST_EMPTY;
          end
          if (fin_status != ST_OK) begin
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              res_load = 1'b1;
              st_d     = ST_HOLD;
            end
          end else begin
            st_d = ST_SEEK;
            case (req.op)
              OP_PUSH_FRONT: begin
                count_d = count_q + CNT_W'(1);
                if (count_q == '0) begin
                  target_d = head_q;
                  tail_d   = ptr_inc(tail_q, cap_eff);
                end else begin
                  target_d = dec_head;
                  head_d   = dec_head;
                end
              end
              OP_PUSH_BACK: begin
                count_d  = count_q + CNT_W'(1);
                target_d = tail_q;
                tail_d   = ptr_inc(tail_q, cap_eff);
              end
              OP_POP_FRONT: begin
                count_d  = count_q - CNT_W'(1);
                target_d = head_q;
                head_d   = ptr_inc(head_q, cap_eff);
              end
              default: begin
                count_d  = count_q - CNT_W'(1);
                target_d = dec_tail;
                tail_d   = dec_tail;
              end
            endcase
          end
        end
      end

      ST_SEEK: begin
        // entry at the port matches: write the new value in or take the entry out
        if (rot_q == target_q) begin
          ring_o.wr_en = is_wr_q;
          if (!is_wr_q) begin
            fin_val = OUT_W'(signed'(port_data_i));
          end
          if (out_free) begin
            out_load = 1'b1;
            st_d     = ST_IDLE;
          end else begin
            res_load = 1'b1;
            st_d     = ST_HOLD;
          end
        end
      end

      ST_HOLD: begin
        fin_status = res_status_q;
        fin_val    = res_val_q;
        if (out_free) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign res_status_d = res_load ? fin_status : res_status_q;
  assign res_val_d    = res_load ? fin_val : res_val_q;
  assign out_status_d = out_load ? fin_status : out_status_q;
  assign out_val_d    = out_load ? fin_val : out_val_q;
  assign out_valid_d  = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rot_q       <= '0;
      cap_q       <= CAP_RST;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
      if (cfg.valid) begin
        cap_q <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q     <= target_d;
    is_wr_q      <= is_wr_d;
    wdata_q      <= wdata_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    out_status_q <= out_status_d;
    out_val_q    <= out_val_d;
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.popped_value = signed'(out_val_q);

endmodule

// ===== rtl/core/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a rotating ring of cells
// push/pop at front or back, capacity-limited ring with wrapping pointers
// ----------------------------------------------------------------------------
// responses: a refused push or pop is answered without a ring access; a successful
//   operation waits in the seek state until the ring has rotated the addressed
//   entry to the single access port at cell 0
// throughput: one word in flight; a new word is taken once the previous one has
//   done its ring access and its response word is held in the output register
// reset: pointers, count and response valid clear, capacity returns to 1024;
//   ring contents are not cleared and no clearing pass runs
module circular_deque (
  input  logic     clk_i,
  input  logic     rst_ni,
  cd_cfg_if.sink   cfg_i,
  cd_req_if.sink   req_i,
  cd_rsp_if.source rsp_o
);
  import cd_pkg::*;

  // cell k holds ring entry (rot + k) mod DEPTH; every cycle the ring moves one
  // cell toward cell 0 and the entry leaving cell 0 wraps into the last cell
  data_t     cell_data [DEPTH];
  ring_ctl_t ring_ctl;

  // sequencer: pointer and count bookkeeping, capacity register, response word
  cd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .port_data_i (cell_data[0]),
    .ring_o      (ring_ctl)
  );

  // row of identical cells; only the last one takes write data, which lands
  // there exactly as the addressed entry leaves cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == DEPTH - 1) begin : g_tail
      cd_cell u_cell (
        .clk_i     (clk_i),
        .shift_i   (cell_data[0]),
        .wr_en_i   (ring_ctl.wr_en),
        .wr_data_i (ring_ctl.wr_data),
        .data_o    (cell_data[k])
      );
    end else begin : g_body
      cd_cell u_cell (
        .clk_i     (clk_i),
        .shift_i   (cell_data[k+1]),
        .wr_en_i   (1'b0),
        .wr_data_i (ring_ctl.wr_data),
        .data_o    (cell_data[k])
      );
    end
  end

endmodule
